>>> rtl/core/pbl_pkg.sv
// Shared types and constants of the polyline box limiter.
package pbl_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned ResSlots = 4;
  localparam int unsigned AddrW    = 4;

  typedef logic signed [CoordW-1:0] coord_t;

  // Configuration register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MAX_X = 2'd1,
    REG_BOX_MIN_Y = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } reg_idx_t;

  // One result word as it waits in the output buffer.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   close;
    logic   last;
  } res_t;

endpackage

>>> rtl/core/polyline_box_limiter.sv
// Polyline box limiter: keeps the parts of a polyline that lie near a limit box.
//
// Vertices arrive on the s_ channel, one word per vertex, with s_tlast set on
// the final vertex of a polyline. Kept points and section end markers leave on
// the m_ channel; m_tuser marks an end marker, m_tlast the final result word of
// one vertex. A vertex may cause no result at all. The limit box is written over
// the APB-style port, by the user only while idle; the block does not enforce it.
//
// A vertex is captured in an input register. Once the result buffer is free, the
// whole result list for it (at most three words in practice, four slots are
// provided) is worked out in a single combinational pass from the input register
// and the line state, and loaded into a small result buffer that drains one word
// per cycle while the receiver is ready. A vertex's pass waits until the previous
// list is drained or leaving with its last word, so the single output channel
// limits the vertex rate. The next vertex is accepted while earlier results still
// drain.
//
// When the receiver stalls, the buffer holds its words and the input register
// fills, after which s_tready falls. Reset clears the box, the line state and
// both the input register and the result buffer.
module polyline_box_limiter (
  input  logic                    clk,
  input  logic                    rst,
  // Vertex input
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [63:0]             s_tdata,   // [31:0] vertex_x, [63:32] vertex_y
  input  logic                    s_tlast,   // line_end
  // Result output
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [63:0]             m_tdata,   // [31:0] point_x, [63:32] point_y
  output logic                    m_tuser,   // section_close
  output logic                    m_tlast,   // run_last
  // Configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [pbl_pkg::AddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pbl_pkg::*;

  // Limit box registers, edges inclusive.
  coord_t box_min_x, box_max_x, box_min_y, box_max_y;

  // Line state.
  coord_t pending_x, pending_y, prev_emit_x, prev_emit_y;
  logic   pending_valid, section_active;

  // Input register.
  logic   in_valid, in_last;
  coord_t in_x, in_y;

  // Result buffer.
  res_t       res_buf [ResSlots];
  logic [1:0] rd_idx;
  logic [2:0] cnt;

  logic buf_free, compute_fire, cfg_write;

  // Results of the combinational pass.
  res_t       slot [ResSlots];
  logic [2:0] n_res;
  coord_t     px_next, py_next, ex_next, ey_next;
  logic       pv_next, sa_next;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_max_x <= '0;
      box_min_y <= '0;
      box_max_y <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_BOX_MIN_X: box_min_x <= pwdata;
        REG_BOX_MAX_X: box_max_x <= pwdata;
        REG_BOX_MIN_Y: box_min_y <= pwdata;
        REG_BOX_MAX_Y: box_max_y <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_BOX_MIN_X: prdata = box_min_x;
      REG_BOX_MAX_X: prdata = box_max_x;
      REG_BOX_MIN_Y: prdata = box_min_y;
      REG_BOX_MAX_Y: prdata = box_max_y;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  // The buffer can take a new list when empty or once its last word leaves this cycle.
  assign buf_free     = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);
  assign compute_fire = in_valid && buf_free;
  assign s_tready     = !in_valid || compute_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (compute_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x    <= s_tdata[31:0];
      in_y    <= s_tdata[63:32];
      in_last <= s_tlast;
    end
  end

  // ------------------------------------------------------------------
  // Single pass over one vertex
  // ------------------------------------------------------------------
  always_comb begin
    logic   in_box, touch, go;
    logic   sa, pv;
    coord_t ex, ey, px, py;
    coord_t lox, hix, loy, hiy;
    logic [2:0] n;

    for (int i = 0; i < ResSlots; i++) slot[i] = '0;
    sa = section_active;
    pv = pending_valid;
    ex = prev_emit_x;
    ey = prev_emit_y;
    px = pending_x;
    py = pending_y;
    n  = 3'd0;

    in_box = (in_x >= box_min_x) && (in_x <= box_max_x) &&
             (in_y >= box_min_y) && (in_y <= box_max_y);
    lox = (px < in_x) ? px : in_x;
    hix = (px < in_x) ? in_x : px;
    loy = (py < in_y) ? py : in_y;
    hiy = (py < in_y) ? in_y : py;
    // With no pending vertex the segment test falls back to the open section.
    touch = pv ? ((lox <= box_max_x) && (hix >= box_min_x) &&
                  (loy <= box_max_y) && (hiy >= box_min_y)) : sa;
    go = in_box || touch;

    if (go) begin
      // Pending vertex first, then the vertex itself; repeats are dropped.
      if (pv) begin
        if (!(sa && px == ex && py == ey)) begin
          slot[n[1:0]].x = px;
          slot[n[1:0]].y = py;
          n  = n + 3'd1;
          ex = px;
          ey = py;
          sa = 1'b1;
        end
        pv = 1'b0;
      end
      if (!(sa && in_x == ex && in_y == ey)) begin
        slot[n[1:0]].x = in_x;
        slot[n[1:0]].y = in_y;
        n  = n + 3'd1;
        ex = in_x;
        ey = in_y;
        sa = 1'b1;
      end
    end else if (sa) begin
      // Leaving the box for good: flush the pending vertex, then end marker.
      if (pv && !(px == ex && py == ey)) begin
        slot[n[1:0]].x = px;
        slot[n[1:0]].y = py;
        n  = n + 3'd1;
        ex = px;
        ey = py;
      end
      slot[n[1:0]].close = 1'b1;
      n  = n + 3'd1;
      sa = 1'b0;
    end

    if (!in_box) begin
      px = in_x;
      py = in_y;
      pv = 1'b1;
    end

    if (in_last) begin
      if (sa) begin
        if (pv && !(px == ex && py == ey)) begin
          slot[n[1:0]].x = px;
          slot[n[1:0]].y = py;
          n  = n + 3'd1;
          ex = px;
          ey = py;
        end
        slot[n[1:0]].close = 1'b1;
        n = n + 3'd1;
      end
      pv = 1'b0;
      sa = 1'b0;
    end

    for (int i = 0; i < ResSlots; i++) begin
      slot[i].last = (n != 3'd0) && (3'(i) == n - 3'd1);
    end

    n_res   = n;
    px_next = px;
    py_next = py;
    ex_next = ex;
    ey_next = ey;
    pv_next = pv;
    sa_next = sa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x      <= '0;
      pending_y      <= '0;
      prev_emit_x    <= '0;
      prev_emit_y    <= '0;
      pending_valid  <= 1'b0;
      section_active <= 1'b0;
    end else if (compute_fire) begin
      pending_x      <= px_next;
      pending_y      <= py_next;
      prev_emit_x    <= ex_next;
      prev_emit_y    <= ey_next;
      pending_valid  <= pv_next;
      section_active <= sa_next;
    end
  end

  // ------------------------------------------------------------------
  // Result buffer
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_idx <= '0;
    end else if (compute_fire) begin
      cnt    <= n_res;
      rd_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      cnt    <= cnt - 3'd1;
      rd_idx <= rd_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (compute_fire) begin
      for (int i = 0; i < ResSlots; i++) res_buf[i] <= slot[i];
    end
  end

  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = {res_buf[rd_idx].y, res_buf[rd_idx].x};
  assign m_tuser  = res_buf[rd_idx].close;
  assign m_tlast  = res_buf[rd_idx].last;

`ifndef SYNTHESIS
  // A new list is only loaded once the previous one is drained or its last word leaves.
  a_load_when_drained: assert property (@(posedge clk) disable iff (rst)
    compute_fire |-> (cnt == 3'd0 || (cnt == 3'd1 && m_tready)))
    else $error("result list loaded over undelivered words");

  // An end marker is always the final word caused by its vertex.
  a_close_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("end marker not flagged as last word");

  // The final vertex of a polyline leaves no section open and nothing pending.
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (compute_fire && in_last) |=> (!pending_valid && !section_active))
    else $error("line state survives end of polyline");

  // Coming out of reset the output buffer and the input register are empty.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (cnt == 3'd0 && !in_valid))
    else $error("buffer not empty after reset");
`endif

endmodule
